### hdl/tec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tec_pkg;

  typedef enum logic [1:0] {
    REG_EMISSIVITY   = 2'd0,
    REG_REFLECTED    = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_index_t;

  localparam int KELVIN_OFS = 27315;
  localparam int K_TOP      = 1027315;
  localparam int ONE_Q16    = 65536;

  localparam int MUL_A_W  = 64;
  localparam int MUL_DIG  = 8;
  localparam int MUL_NDIG = 5;
  localparam int MUL_B_W  = MUL_DIG * MUL_NDIG;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam int SQRT_W   = 90;
  localparam int ROOT_W   = SQRT_W / 2;

  localparam int DIV_N_W  = 33;
  localparam int DIV_D_W  = 17;

  localparam int CFG_W    = 19;

  localparam logic signed [20:0] MIN_INIT = 21'sd1048575;
  localparam logic signed [20:0] MAX_INIT = -21'sd1048576;

endpackage

`default_nettype wire

### hdl/tec_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module tec_mul
  import tec_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [MUL_P_W-1:0]      prod
);

  logic                          busy_r, done_r;
  logic [$clog2(MUL_NDIG)-1:0]   cnt_r;
  logic [MUL_A_W-1:0]            a_r;
  logic [MUL_B_W-1:0]            b_r;
  logic [MUL_P_W-1:0]            acc_r;
  logic [MUL_A_W+MUL_DIG-1:0]    part;

  assign part = a_r * b_r[MUL_B_W-1 -: MUL_DIG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(MUL_NDIG))'(MUL_NDIG - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << MUL_DIG) + MUL_P_W'(part);
      b_r   <= b_r << MUL_DIG;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

### hdl/tec_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module tec_sqrt
  import tec_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SQRT_W-1:0] x,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int REM_W = ROOT_W + 3;

  logic                        busy_r, done_r;
  logic [$clog2(ROOT_W)-1:0]   cnt_r;
  logic [SQRT_W-1:0]           x_r;
  logic [REM_W-1:0]            rem_r;
  logic [ROOT_W-1:0]           root_r;
  logic [REM_W+1:0]            rem_sh, trial;

  assign rem_sh = {rem_r, x_r[SQRT_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(ROOT_W))'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r <= x_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= REM_W'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

### hdl/tec_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tec_div
  import tec_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] num,
  input  wire logic [DIV_D_W-1:0] den,
  output logic                    done,
  output logic [DIV_N_W-1:0]      quo
);

  logic                        busy_r, done_r;
  logic [$clog2(DIV_N_W)-1:0]  cnt_r;
  logic [DIV_N_W-1:0]          n_r, q_r;
  logic [DIV_D_W-1:0]          d_r, rem_r;
  logic [DIV_D_W:0]            rem_sh;

  assign rem_sh = {rem_r, n_r[DIV_N_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(DIV_N_W))'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      n_r <= n_r << 1;
      if (rem_sh >= {1'b0, d_r}) begin
        rem_r <= DIV_D_W'(rem_sh - {1'b0, d_r});
        q_r   <= {q_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_r <= DIV_D_W'(rem_sh);
        q_r   <= {q_r[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

### hdl/thermal_emissivity_correction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// pass-through and invalid pixels skip the arithmetic and go straight to the output state
// throughput: one pixel at a time; the two 45-step square roots dominate, with three
//   5-digit multiplies on the shared multiplier
// after an emissivity or reflected temperature write, the 33-step divider and three multiplies
//   rebuild the derived constants before the next pixel
// reset: control, counters and statistics cleared, inverse emissivity set to unity, reflected contribution cleared

module thermal_emissivity_correction_unit
  import tec_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [18:0] in_apparent_temp,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [20:0]     out_corrected_temp,
  output logic                   out_pixel_invalid,
  output logic                   out_frame_done,
  output logic                   out_frame_error,
  output logic signed [20:0]     out_min_temp,
  output logic [9:0]             out_min_x,
  output logic [9:0]             out_min_y,
  output logic signed [20:0]     out_max_temp,
  output logic [9:0]             out_max_x,
  output logic [9:0]             out_max_y,
  output logic signed [20:0]     out_center_temp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = CW + 1;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_DIV  = 11'b00000000010,
    ST_RSQ  = 11'b00000000100,
    ST_RP4  = 11'b00000001000,
    ST_RCON = 11'b00000010000,
    ST_PSQ  = 11'b00000100000,
    ST_PP4  = 11'b00001000000,
    ST_PINV = 11'b00010000000,
    ST_RT1  = 11'b00100000000,
    ST_RT2  = 11'b01000000000,
    ST_FIN  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   issued_r, issued_nxt;

  logic [16:0]        emis_r;
  logic signed [18:0] refl_r;
  logic [10:0]        fw_r, fh_r;
  logic [32:0]        inv_r;
  logic [56:0]        contrib_r, diff_r;
  logic [18:0]        k_r;
  logic signed [20:0] corr_r;
  logic               inv_pix_r;

  logic [CW-1:0]      col_r, row_r;
  logic signed [20:0] min_r, max_r, center_r;
  logic [9:0]         min_x_r, min_y_r, max_x_r, max_y_r;
  logic               err_r;

  logic               out_valid_r;
  logic signed [20:0] o_corr_r, o_min_r, o_max_r, o_center_r;
  logic               o_inv_r, o_done_r, o_err_r;
  logic [9:0]         o_min_x_r, o_min_y_r, o_max_x_r, o_max_y_r;

  logic [16:0]          eff_emis;
  logic signed [19:0]   kr_s, kp_s;
  logic [18:0]          kr_u;
  logic                 in_acc, cfg_acc, fin_go, in_bad;

  logic                 mul_start, mul_done;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_prod;
  logic                 sq_start, sq_done;
  logic [SQRT_W-1:0]    sq_x;
  logic [ROOT_W-1:0]    sq_root;
  logic                 div_start, div_done;
  logic [DIV_N_W-1:0]   div_quo;

  logic [56:0]          p_val;
  logic [ROOT_W-1:0]    k_sat;
  logic [SW-1:0]        w_eff, h_eff, col_e, row_e;
  logic                 last_col, last_row, center_hit, new_min, new_max;
  logic                 err_n;
  logic signed [20:0]   min_n, max_n, center_n;
  logic [9:0]           min_x_n, min_y_n, max_x_n, max_y_n;

  assign eff_emis = (emis_r == 17'd0) ? 17'd1 :
                    (emis_r > 17'(ONE_Q16)) ? 17'(ONE_Q16) : emis_r;
  assign kr_s = 20'(refl_r) + 20'sd27315;
  assign kr_u = kr_s[19] ? 19'd0 : kr_s[18:0];
  assign kp_s = 20'(in_apparent_temp) + 20'sd27315;
  assign in_bad = int'(in_apparent_temp) < -KELVIN_OFS;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && !in_stall;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign p_val = mul_prod[72:16];
  assign k_sat = (sq_root > ROOT_W'(K_TOP)) ? ROOT_W'(K_TOP) : sq_root;

  assign mul_start = !issued_r && ((state_r == ST_RSQ) || (state_r == ST_RP4) ||
                     (state_r == ST_RCON) || (state_r == ST_PSQ) ||
                     (state_r == ST_PP4) || (state_r == ST_PINV));
  assign sq_start  = !issued_r && ((state_r == ST_RT1) || (state_r == ST_RT2));
  assign div_start = !issued_r && (state_r == ST_DIV);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sq_x  = '0;
    unique case (state_r)
      ST_RSQ: begin
        mul_a = MUL_A_W'(kr_u);
        mul_b = MUL_B_W'(kr_u);
      end
      ST_PSQ: begin
        mul_a = MUL_A_W'(k_r);
        mul_b = MUL_B_W'(k_r);
      end
      ST_RP4, ST_PP4: begin
        mul_a = MUL_A_W'(mul_prod[37:0]);
        mul_b = MUL_B_W'(mul_prod[37:0]);
      end
      ST_RCON: begin
        mul_a = MUL_A_W'(p_val);
        mul_b = MUL_B_W'(17'(ONE_Q16) - eff_emis);
      end
      ST_PINV: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = MUL_B_W'(inv_r);
      end
      ST_RT1: sq_x = SQRT_W'(mul_prod[88:0]);
      ST_RT2: sq_x = SQRT_W'(sq_root);
      default: ;
    endcase
  end

  tec_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tec_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  tec_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (DIV_N_W'(33'h1_0000_0000) + DIV_N_W'(eff_emis >> 1)),
    .den   (eff_emis),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    if (mul_start || sq_start || div_start) begin
      issued_nxt = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          if ((cfg_index == REG_EMISSIVITY) || (cfg_index == REG_REFLECTED)) begin
            state_nxt = ST_DIV;
          end
        end else if (in_acc) begin
          if (in_bad || (eff_emis == 17'(ONE_Q16))) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_PSQ;
          end
        end
      end
      ST_DIV: if (div_done) begin
        state_nxt  = ST_RSQ;
        issued_nxt = 1'b0;
      end
      ST_RSQ: if (mul_done) begin
        state_nxt  = ST_RP4;
        issued_nxt = 1'b0;
      end
      ST_RP4: if (mul_done) begin
        state_nxt  = ST_RCON;
        issued_nxt = 1'b0;
      end
      ST_RCON: if (mul_done) begin
        state_nxt  = ST_IDLE;
        issued_nxt = 1'b0;
      end
      ST_PSQ: if (mul_done) begin
        state_nxt  = ST_PP4;
        issued_nxt = 1'b0;
      end
      ST_PP4: if (mul_done) begin
        state_nxt  = ST_PINV;
        issued_nxt = 1'b0;
      end
      ST_PINV: if (mul_done) begin
        state_nxt  = ST_RT1;
        issued_nxt = 1'b0;
      end
      ST_RT1: if (sq_done) begin
        state_nxt  = ST_RT2;
        issued_nxt = 1'b0;
      end
      ST_RT2: if (sq_done) begin
        state_nxt  = ST_FIN;
        issued_nxt = 1'b0;
      end
      ST_FIN: if (fin_go) begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt  = ST_IDLE;
        issued_nxt = 1'b0;
      end
    endcase
  end

  // frame bookkeeping
  always_comb begin
    w_eff = (fw_r == 11'd0) ? SW'(1) : ((32'(fw_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(fw_r));
    h_eff = (fh_r == 11'd0) ? SW'(1) : ((32'(fh_r) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(fh_r));
    col_e = {1'b0, col_r};
    row_e = {1'b0, row_r};
    last_col   = (col_e + SW'(1)) >= w_eff;
    last_row   = (row_e + SW'(1)) >= h_eff;
    center_hit = (col_e == (w_eff >> 1)) && (row_e == (h_eff >> 1));
    new_min    = !inv_pix_r && (corr_r < min_r);
    new_max    = !inv_pix_r && (corr_r > max_r);
    err_n      = err_r || inv_pix_r;
    min_n      = new_min ? corr_r : min_r;
    max_n      = new_max ? corr_r : max_r;
    min_x_n    = new_min ? 10'(col_r) : min_x_r;
    min_y_n    = new_min ? 10'(row_r) : min_y_r;
    max_x_n    = new_max ? 10'(col_r) : max_x_r;
    max_y_n    = new_max ? 10'(row_r) : max_y_r;
    center_n   = center_hit ? corr_r : center_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      emis_r      <= 17'(ONE_Q16);
      refl_r      <= 19'sd2000;
      fw_r        <= 11'd160;
      fh_r        <= 11'd120;
      inv_r       <= 33'(ONE_Q16);
      contrib_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      min_r       <= MIN_INIT;
      max_r       <= MAX_INIT;
      min_x_r     <= '0;
      min_y_r     <= '0;
      max_x_r     <= '0;
      max_y_r     <= '0;
      center_r    <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_EMISSIVITY:   emis_r <= cfg_data[16:0];
          REG_REFLECTED:    refl_r <= cfg_data;
          REG_FRAME_WIDTH:  fw_r   <= cfg_data[10:0];
          REG_FRAME_HEIGHT: fh_r   <= cfg_data[10:0];
          default: ;
        endcase
      end
      if ((state_r == ST_DIV) && div_done) begin
        inv_r <= div_quo;
      end
      if ((state_r == ST_RCON) && mul_done) begin
        contrib_r <= p_val;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (last_col && last_row) begin
          col_r    <= '0;
          row_r    <= '0;
          min_r    <= MIN_INIT;
          max_r    <= MAX_INIT;
          min_x_r  <= '0;
          min_y_r  <= '0;
          max_x_r  <= '0;
          max_y_r  <= '0;
          center_r <= '0;
          err_r    <= 1'b0;
        end else begin
          if (last_col) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
          min_r    <= min_n;
          max_r    <= max_n;
          min_x_r  <= min_x_n;
          min_y_r  <= min_y_n;
          max_x_r  <= max_x_n;
          max_y_r  <= max_y_n;
          center_r <= center_n;
          err_r    <= err_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      inv_pix_r <= in_bad;
      k_r       <= kp_s[18:0];
      corr_r    <= in_bad ? 21'sd0 : 21'(in_apparent_temp);
    end
    if ((state_r == ST_PP4) && mul_done) begin
      diff_r <= (p_val > contrib_r) ? (p_val - contrib_r) : 57'd0;
    end
    if ((state_r == ST_RT2) && sq_done) begin
      corr_r <= 21'(24'(k_sat) - 24'(KELVIN_OFS));
    end
    if (fin_go) begin
      o_corr_r <= corr_r;
      o_inv_r  <= inv_pix_r;
      o_done_r <= last_col && last_row;
      if (last_col && last_row) begin
        o_err_r    <= err_n;
        o_min_r    <= min_n;
        o_min_x_r  <= min_x_n;
        o_min_y_r  <= min_y_n;
        o_max_r    <= max_n;
        o_max_x_r  <= max_x_n;
        o_max_y_r  <= max_y_n;
        o_center_r <= center_n;
      end else begin
        o_err_r    <= 1'b0;
        o_min_r    <= '0;
        o_min_x_r  <= '0;
        o_min_y_r  <= '0;
        o_max_r    <= '0;
        o_max_x_r  <= '0;
        o_max_y_r  <= '0;
        o_center_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_corrected_temp = o_corr_r;
  assign out_pixel_invalid  = o_inv_r;
  assign out_frame_done     = o_done_r;
  assign out_frame_error    = o_err_r;
  assign out_min_temp       = o_min_r;
  assign out_min_x          = o_min_x_r;
  assign out_min_y          = o_min_y_r;
  assign out_max_temp       = o_max_r;
  assign out_max_x          = o_max_x_r;
  assign out_max_y          = o_max_y_r;
  assign out_center_temp    = o_center_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("pixel accepted but sequencer stayed idle");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_inv_r) |-> (o_corr_r == 21'sd0))
    else $error("invalid pixel with nonzero result");

  a_stats_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_done_r) |-> (!o_err_r && (o_center_r == 21'sd0)))
    else $error("frame statistics shown on a non-final word");

endmodule

`default_nettype wire
